// ===== rtl/sbh_pkg.sv =====
// Shared package for the spatial bin histogram.
// Holds operation and register codes, fixed field widths and reset values.
// No dependencies.
package sbh_pkg;

  localparam int NUM_BINS_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 20;
  localparam int NUM_TYPES_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 24;

  localparam int OP_W       = 2;
  localparam int KIND_W     = 4;
  localparam int BINNUM_W   = 8;
  localparam int BIN_SIZE_W = 23;
  localparam int BIU_W      = 9;
  localparam int MASK_W     = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [BIN_SIZE_W-1:0] BIN_SIZE_RST = BIN_SIZE_W'(256);
  localparam logic [BIU_W-1:0]      BIU_RST      = BIU_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } sbh_op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_X      = 2'd0,
    MODE_Y      = 2'd1,
    MODE_Z      = 2'd2,
    MODE_RADIAL = 2'd3
  } sbh_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_MODE   = 3'd0,
    REG_AXIS_LOW    = 3'd1,
    REG_BIN_SIZE    = 3'd2,
    REG_CENTER_X    = 3'd3,
    REG_CENTER_Y    = 3'd4,
    REG_BINS_IN_USE = 3'd5,
    REG_TYPE_MASK   = 3'd6,
    REG_SPARE       = 3'd7
  } sbh_reg_t;

  typedef struct packed {
    logic start;
    logic radial;
  } sbh_bin_ctl_t;

endpackage

// ===== rtl/sbh_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sbh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sbh_binner.sv =====
// Bin finder: serial square-sum and digit-by-digit square root (radial mode only), restoring divide, clamp.
// Depends on sbh_pkg.
module sbh_binner #(
  parameter int COORD_WIDTH = sbh_pkg::COORD_WIDTH_DEF,
  parameter int NUM_BINS    = sbh_pkg::NUM_BINS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sbh_pkg::sbh_bin_ctl_t                ctl,
  input  logic signed [COORD_WIDTH:0]          dx,
  input  logic signed [COORD_WIDTH:0]          dy,
  input  logic [sbh_pkg::BIN_SIZE_W-1:0]       bs,
  input  logic [$clog2(NUM_BINS+1)-1:0]        nb,
  output logic                                 done,
  output logic [$clog2(NUM_BINS)-1:0]          bin
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int MW   = (DW > 31) ? 31 : DW;
  localparam int SW   = 2 * MW + 2;
  localparam int NP   = MW + 1;
  localparam int RW   = NP + 2;
  localparam int DDW  = COORD_WIDTH + 2;
  localparam int BSW  = sbh_pkg::BIN_SIZE_W;
  localparam int NBW  = $clog2(NUM_BINS + 1);
  localparam int AW   = $clog2(NUM_BINS);
  localparam int CNTW = $clog2(SW + 1);
  localparam logic [DW-1:0] MAG_LIM = DW'((64'd1 << MW) - 64'd1);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SQ   = 5'b00010,
    B_RT   = 5'b00100,
    B_DV   = 5'b01000,
    B_CL   = 5'b10000
  } bstate_t;

  bstate_t state_r, state_nxt;
  logic [MW-1:0]   ax_r, ax_nxt, ay_r, ay_nxt, xs_r, xs_nxt, ys_r, ys_nxt;
  logic [SW-1:0]   acc_r, acc_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic [NP-1:0]   root_r, root_nxt;
  logic [DDW-1:0]  dq_r, dq_nxt;
  logic [BSW-1:0]  drem_r, drem_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  logic [DW-1:0]   magx, magy;
  logic [RW-1:0]   rem_sh, trial;
  logic            rt_ge, dv_ge;
  logic [BSW:0]    dv_t;

  always_comb begin
    magx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    magy = dy[DW-1] ? DW'(-dy) : DW'(dy);
    if (magx > MAG_LIM) magx = MAG_LIM;
    if (magy > MAG_LIM) magy = MAG_LIM;
    rem_sh = {rem_r[RW-3:0], acc_r[SW-1:SW-2]};
    trial  = {root_r, 2'b01};
    rt_ge  = rem_sh >= trial;
    dv_t   = {drem_r, dq_r[DDW-1]};
    dv_ge  = dv_t >= {1'b0, bs};
  end

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    xs_nxt    = xs_r;
    ys_nxt    = ys_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    dq_nxt    = dq_r;
    drem_nxt  = drem_r;
    cnt_nxt   = cnt_r - CNTW'(1);
    done      = 1'b0;
    bin       = '0;
    unique case (state_r)
      B_IDLE: begin
        cnt_nxt = cnt_r;
        if (ctl.start) begin
          if (ctl.radial) begin
            ax_nxt    = MW'(magx);
            ay_nxt    = MW'(magy);
            xs_nxt    = MW'(magx);
            ys_nxt    = MW'(magy);
            acc_nxt   = '0;
            cnt_nxt   = CNTW'(MW);
            state_nxt = B_SQ;
          end else if (dx[DW-1]) begin
            dq_nxt    = '0;
            state_nxt = B_CL;
          end else begin
            dq_nxt    = DDW'(unsigned'(dx));
            drem_nxt  = '0;
            cnt_nxt   = CNTW'(DDW);
            state_nxt = B_DV;
          end
        end
      end
      B_SQ: begin
        acc_nxt = {acc_r[SW-2:0], 1'b0}
                  + (xs_r[MW-1] ? SW'(ax_r) : '0)
                  + (ys_r[MW-1] ? SW'(ay_r) : '0);
        xs_nxt  = {xs_r[MW-2:0], 1'b0};
        ys_nxt  = {ys_r[MW-2:0], 1'b0};
        if (cnt_r == CNTW'(1)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = CNTW'(NP);
          state_nxt = B_RT;
        end
      end
      B_RT: begin
        acc_nxt  = {acc_r[SW-3:0], 2'b00};
        rem_nxt  = rt_ge ? rem_sh - trial : rem_sh;
        root_nxt = {root_r[NP-2:0], rt_ge};
        if (cnt_r == CNTW'(1)) begin
          dq_nxt    = DDW'({root_r[NP-2:0], rt_ge});
          drem_nxt  = '0;
          cnt_nxt   = CNTW'(DDW);
          state_nxt = B_DV;
        end
      end
      B_DV: begin
        drem_nxt = dv_ge ? BSW'(dv_t - {1'b0, bs}) : dv_t[BSW-1:0];
        dq_nxt   = {dq_r[DDW-2:0], dv_ge};
        if (cnt_r == CNTW'(1)) begin
          state_nxt = B_CL;
        end
      end
      B_CL: begin
        done      = 1'b1;
        bin       = (dq_r >= DDW'(nb)) ? AW'(nb - NBW'(1)) : AW'(dq_r);
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    xs_r   <= xs_nxt;
    ys_r   <= ys_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    dq_r   <= dq_nxt;
    drem_r <= drem_nxt;
  end

endmodule

// ===== rtl/spatial_bin_histogram_top.sv =====
// Spatial bin histogram top level: config registers, sequencer, count RAM.
// Depends on sbh_pkg, sbh_ram and sbh_binner.
//
// One item at a time. An add on an axis runs the bit-serial divide loop in the binner
// (skipped for an offset below the axis low), in radial mode the bit-serial square-sum,
// square-root and divide loops, and then a RAM read-modify-write. A read passes through
// the RAM read and update states. A clear, and the clearing pass after reset, sweep the
// count RAM one entry per cycle, during which no input beat is taken. A finished result
// sits in an output register, so the next input beat is taken while it waits. Config
// writes are always ready and are meant for idle time.
module spatial_bin_histogram_top #(
  parameter int NUM_BINS    = sbh_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = sbh_pkg::COUNT_WIDTH_DEF,
  parameter int NUM_TYPES   = sbh_pkg::NUM_TYPES_DEF,
  parameter int COORD_WIDTH = sbh_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sbh_pkg::OP_W-1:0]         in_operation,
  input  logic signed [COORD_WIDTH-1:0]    in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]    in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]    in_pos_z,
  input  logic [sbh_pkg::KIND_W-1:0]       in_atom_kind,
  input  logic [sbh_pkg::BINNUM_W-1:0]     in_bin_select,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sbh_pkg::BINNUM_W-1:0]     out_bin_number,
  output logic [COUNT_WIDTH-1:0]           out_target_count,
  output logic [COUNT_WIDTH-1:0]           out_total_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbh_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW  = $clog2(NUM_BINS);
  localparam int NBW = $clog2(NUM_BINS + 1);
  localparam int CW  = COORD_WIDTH;
  localparam int BNW = sbh_pkg::BINNUM_W;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_BIN  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_CLR  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [sbh_pkg::MODE_W-1:0]     mode_r;
  logic signed [CW-1:0]           axis_low_r, center_x_r, center_y_r;
  logic [sbh_pkg::BIN_SIZE_W-1:0] bin_size_r;
  logic [sbh_pkg::BIU_W-1:0]      biu_r;
  logic [sbh_pkg::MASK_W-1:0]     mask_r;

  logic                   is_add_r, is_add_nxt;
  logic                   tgt_r, tgt_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [BNW-1:0]         bnum_r, bnum_nxt;
  logic [COUNT_WIDTH-1:0] rtgt_r, rtgt_nxt, rtot_r, rtot_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;

  logic                   ov_r, ov_nxt;
  logic [BNW-1:0]         obin_r, obin_nxt;
  logic [COUNT_WIDTH-1:0] otgt_r, otgt_nxt, otot_r, otot_nxt;

  sbh_pkg::sbh_bin_ctl_t          bctl;
  logic signed [CW:0]             bdx, bdy;
  logic [sbh_pkg::BIN_SIZE_W-1:0] bs_eff;
  logic [NBW-1:0]                 nb_eff;
  logic                           bdone;
  logic [AW-1:0]                  bbin;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [2*COUNT_WIDTH-1:0]   ram_wdata, ram_rdata;
  logic [COUNT_WIDTH-1:0]     cur_tgt, cur_tot, new_tgt, new_tot;
  logic                       in_acc, out_free;
  logic signed [CW-1:0]       axis_pos;

  assign cfg_ready        = 1'b1;
  assign in_stall         = (state_r != S_IDLE);
  assign in_acc           = in_valid && !in_stall;
  assign out_valid        = ov_r;
  assign out_bin_number   = obin_r;
  assign out_target_count = otgt_r;
  assign out_total_count  = otot_r;
  assign out_free         = !ov_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= sbh_pkg::MODE_X;
      axis_low_r <= '0;
      bin_size_r <= sbh_pkg::BIN_SIZE_RST;
      center_x_r <= '0;
      center_y_r <= '0;
      biu_r      <= sbh_pkg::BIU_RST;
      mask_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sbh_pkg::REG_AXIS_MODE:   mode_r     <= cfg_data[sbh_pkg::MODE_W-1:0];
        sbh_pkg::REG_AXIS_LOW:    axis_low_r <= cfg_data[CW-1:0];
        sbh_pkg::REG_BIN_SIZE:    bin_size_r <= cfg_data[sbh_pkg::BIN_SIZE_W-1:0];
        sbh_pkg::REG_CENTER_X:    center_x_r <= cfg_data[CW-1:0];
        sbh_pkg::REG_CENTER_Y:    center_y_r <= cfg_data[CW-1:0];
        sbh_pkg::REG_BINS_IN_USE: biu_r      <= cfg_data[sbh_pkg::BIU_W-1:0];
        sbh_pkg::REG_TYPE_MASK:   mask_r     <= cfg_data[sbh_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bs_eff = (bin_size_r == '0) ? sbh_pkg::BIN_SIZE_W'(1) : bin_size_r;
    if (biu_r == '0) begin
      nb_eff = NBW'(1);
    end else if (32'(biu_r) > NUM_BINS) begin
      nb_eff = NBW'(NUM_BINS);
    end else begin
      nb_eff = NBW'(biu_r);
    end
    case (mode_r)
      sbh_pkg::MODE_Y: axis_pos = in_pos_y;
      sbh_pkg::MODE_Z: axis_pos = in_pos_z;
      default:         axis_pos = in_pos_x;
    endcase
    bctl.radial = (mode_r == sbh_pkg::MODE_RADIAL);
    if (bctl.radial) begin
      bdx = (CW+1)'(in_pos_x) - (CW+1)'(center_x_r);
      bdy = (CW+1)'(in_pos_y) - (CW+1)'(center_y_r);
    end else begin
      bdx = (CW+1)'(axis_pos) - (CW+1)'(axis_low_r);
      bdy = '0;
    end
    bctl.start = in_acc && (in_operation == sbh_pkg::OP_ADD);
  end

  sbh_binner #(
    .COORD_WIDTH (COORD_WIDTH),
    .NUM_BINS    (NUM_BINS)
  ) u_binner (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bctl),
    .dx    (bdx),
    .dy    (bdy),
    .bs    (bs_eff),
    .nb    (nb_eff),
    .done  (bdone),
    .bin   (bbin)
  );

  sbh_ram #(
    .WIDTH (2 * COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_tgt = ram_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
    cur_tot = ram_rdata[COUNT_WIDTH-1:0];
    new_tot = (&cur_tot) ? cur_tot : cur_tot + COUNT_WIDTH'(1);
    new_tgt = (tgt_r && !(&cur_tgt)) ? cur_tgt + COUNT_WIDTH'(1) : cur_tgt;
  end

  always_comb begin
    state_nxt  = state_r;
    is_add_nxt = is_add_r;
    tgt_nxt    = tgt_r;
    addr_nxt   = addr_r;
    bnum_nxt   = bnum_r;
    rtgt_nxt   = rtgt_r;
    rtot_nxt   = rtot_r;
    clr_nxt    = clr_r;
    ram_we     = 1'b0;
    ram_waddr  = clr_r;
    ram_wdata  = '0;
    ov_nxt     = ov_r && out_stall;
    obin_nxt   = obin_r;
    otgt_nxt   = otgt_r;
    otot_nxt   = otot_r;
    unique case (state_r)
      S_INIT, S_CLR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(NUM_BINS - 1)) begin
          clr_nxt   = '0;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_OUT;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          bnum_nxt   = '0;
          rtgt_nxt   = '0;
          rtot_nxt   = '0;
          is_add_nxt = 1'b0;
          unique case (in_operation)
            sbh_pkg::OP_ADD: begin
              is_add_nxt = 1'b1;
              tgt_nxt    = (32'(in_atom_kind) < NUM_TYPES) && mask_r[in_atom_kind];
              state_nxt  = S_BIN;
            end
            sbh_pkg::OP_READ: begin
              bnum_nxt = in_bin_select;
              if (32'(in_bin_select) < NUM_BINS) begin
                addr_nxt  = AW'(in_bin_select);
                state_nxt = S_RD;
              end else begin
                state_nxt = S_OUT;
              end
            end
            sbh_pkg::OP_CLEAR: state_nxt = S_CLR;
            default:           state_nxt = S_OUT;
          endcase
        end
      end
      S_BIN: begin
        if (bdone) begin
          addr_nxt  = bbin;
          bnum_nxt  = BNW'(bbin);
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_UPD;
      S_UPD: begin
        if (is_add_r) begin
          ram_we    = 1'b1;
          ram_waddr = addr_r;
          ram_wdata = {new_tgt, new_tot};
          rtgt_nxt  = new_tgt;
          rtot_nxt  = new_tot;
        end else begin
          rtgt_nxt  = cur_tgt;
          rtot_nxt  = cur_tot;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          obin_nxt  = bnum_r;
          otgt_nxt  = rtgt_r;
          otot_nxt  = rtot_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    is_add_r <= is_add_nxt;
    tgt_r    <= tgt_nxt;
    addr_r   <= addr_nxt;
    bnum_r   <= bnum_nxt;
    rtgt_r   <= rtgt_nxt;
    rtot_r   <= rtot_nxt;
    obin_r   <= obin_nxt;
    otgt_r   <= otgt_nxt;
    otot_r   <= otot_nxt;
  end

  a_done_in_bin: assert property (@(posedge clk) disable iff (!rst_n)
    bdone |-> (state_r == S_BIN))
    else $error("binner done outside bin state");

  a_bin_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    bdone |-> (NBW'(bbin) < nb_eff))
    else $error("bin past bins in use");

  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INIT || state_r == S_CLR || (state_r == S_UPD && is_add_r)))
    else $error("unexpected count write");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BIN) |=> (state_r == S_BIN || state_r == S_RD))
    else $error("bin search left early");

endmodule
